[rtl/wls_pkg.sv]
package wls_pkg;

  localparam int MAX_LEN = 16;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_word;
  } in_t;

  typedef struct packed {
    logic [7:0] sorted_symbol;
    logic       last_out;
  } out_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic       insert;
    logic       drain;
    logic [7:0] symbol;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       greater;
  } cell_link_t;

endpackage

[rtl/wls_cell.sv]
module wls_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wls_pkg::cell_ctrl_t ctrl,
  input  wls_pkg::cell_link_t left,
  input  wls_pkg::cell_link_t right,
  output wls_pkg::cell_link_t self
);
  import wls_pkg::*;

  logic [7:0] value_r;
  logic [7:0] value_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic       greater;
  logic       first_free;

  // A held character larger than the new one moves one place up.
  assign greater    = valid_r && (value_r > ctrl.symbol);
  assign first_free = !valid_r && left.valid;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (left.greater) begin
        value_nxt = left.value;
      end else if (greater || first_free) begin
        value_nxt = ctrl.symbol;
      end
      valid_nxt = valid_r || left.valid;
    end else if (ctrl.drain) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign self.value   = value_r;
  assign self.valid   = valid_r;
  assign self.greater = greater;

endmodule

[rtl/word_letter_sorter.sv]
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-------------------------------
// input    | start, busy, in_word         | taken when start && !busy
// result   | out_strobe, out_word         | strobed while draining, no stall
//
// Each character that fits is inserted in sorted place as it is taken,
// so characters without the end flag are taken back to back. After the
// flagged character the chain shifts toward cell zero one word per cycle
// with busy high, and no new character is taken until the drain ends.
// Reset clears all cell valid bits and the drain state.
module word_letter_sorter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  wls_pkg::in_t  in_word,
  output logic          out_strobe,
  output wls_pkg::out_t out_word
);
  import wls_pkg::*;

  logic        draining_r;
  logic        draining_nxt;
  logic        accept;
  logic        full;
  cell_ctrl_t  ctrl;
  cell_link_t  link [MAX_LEN];
  cell_link_t  left_edge;
  cell_link_t  right_edge;
  logic [MAX_LEN-1:0] valid_vec;
  logic [MAX_LEN:0]   valid_plus;

  assign accept = start && !draining_r;
  assign full   = link[MAX_LEN-1].valid;

  // Characters beyond the store size are dropped, but their flag still counts.
  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = draining_r;
  assign ctrl.symbol = in_word.symbol;

  assign left_edge  = '{value: 8'd0, valid: 1'b1, greater: 1'b0};
  assign right_edge = '{value: 8'd0, valid: 1'b0, greater: 1'b0};

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    wls_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .left  ((i == 0) ? left_edge : link[(i == 0) ? 0 : i - 1]),
      .right ((i == MAX_LEN - 1) ? right_edge : link[(i == MAX_LEN - 1) ? i : i + 1]),
      .self  (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    draining_nxt = draining_r;
    if (draining_r) begin
      if (!link[1].valid) begin
        draining_nxt = 1'b0;
      end
    end else if (accept && in_word.end_of_word) begin
      draining_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
    end
  end

  assign busy                   = draining_r;
  assign out_strobe             = draining_r;
  assign out_word.sorted_symbol = link[0].value;
  assign out_word.last_out      = !link[1].valid;

  assign valid_plus = {1'b0, valid_vec} + {{MAX_LEN{1'b0}}, 1'b1};

  a_emit_from_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> link[0].valid)
    else $error("result word taken from an empty cell");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last_out) |=> (!busy && !link[0].valid))
    else $error("drain did not end after the last word");

  a_mid_word_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_word.end_of_word) |=> !out_strobe)
    else $error("result word without an end of word");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(valid_plus))
    else $error("held characters do not form a contiguous prefix");

endmodule

[tb/tb_word_letter_sorter.sv]
module tb_word_letter_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import wls_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_word;
  logic out_strobe;
  out_t out_word;

  word_letter_sorter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // Characters waiting to be sent, and sorted characters waiting to come back.
  in_t  char_queue[$];
  out_t key_queue[$];

  // Predictor copy of the character store.
  logic [7:0] held_chars[MAX_LEN];
  int         held_cnt;

  int errors;
  int chars_sent;
  int words_sent;
  int keys_seen;
  int overlong_words;
  logic take;
  logic hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store the character and, on the flagged one, queue the sorted word.
  task automatic absorb_char(input in_t w);
    logic [7:0] buf_chars[MAX_LEN];
    logic [7:0] pick;
    int         a;
    int         b;
    out_t       r;
    if (held_cnt < MAX_LEN) begin
      held_chars[held_cnt] = w.symbol;
      held_cnt++;
    end else if (held_cnt == MAX_LEN) begin
      overlong_words++;
      held_cnt++;
    end
    if (w.end_of_word) begin
      if (held_cnt > MAX_LEN) held_cnt = MAX_LEN;
      for (a = 0; a < held_cnt; a++) buf_chars[a] = held_chars[a];
      for (a = 1; a < held_cnt; a++) begin
        pick = buf_chars[a];
        b = a;
        while (b > 0 && buf_chars[b-1] > pick) begin
          buf_chars[b] = buf_chars[b-1];
          b--;
        end
        buf_chars[b] = pick;
      end
      for (a = 0; a < held_cnt; a++) begin
        r.sorted_symbol = buf_chars[a];
        r.last_out = (a == held_cnt - 1);
        key_queue = {key_queue, r};
      end
      held_cnt = 0;
      words_sent++;
    end
  endtask

  task automatic add_char(input logic [7:0] sym, input logic eow);
    in_t w;
    w.symbol = sym;
    w.end_of_word = eow;
    char_queue = {char_queue, w};
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 60) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // Driver: a character is taken on an edge where start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_word <= '0;
    end else begin
      take = start && !busy;
      if (take) begin
        absorb_char(in_word);
        void'(char_queue.pop_front());
        chars_sent++;
      end
      if (!start || take) begin
        // No gaps at all for a stretch in the middle of the run.
        hold_off = !(chars_sent >= 70 && chars_sent < 130) && ($urandom_range(99) < 15);
        if (char_queue.size() != 0 && !hold_off) begin
          start   <= 1'b1;
          in_word <= char_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      keys_seen++;
      if (key_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected sorted character: actual %h/%b", $time,
                 out_word.sorted_symbol, out_word.last_out);
      end else begin
        if (out_word.sorted_symbol !== key_queue[0].sorted_symbol) begin
          errors++;
          $display("%0t: sorted_symbol mismatch: expected %h actual %h", $time,
                   key_queue[0].sorted_symbol, out_word.sorted_symbol);
        end
        if (out_word.last_out !== key_queue[0].last_out) begin
          errors++;
          $display("%0t: last_out mismatch: expected %b actual %b", $time,
                   key_queue[0].last_out, out_word.last_out);
        end
        void'(key_queue.pop_front());
      end
    end
  end

  initial begin
    int k;
    int len;
    int r;
    int guard;
    rst_n = 1'b0;
    held_cnt = 0;
    errors = 0;
    chars_sent = 0;
    words_sent = 0;
    keys_seen = 0;
    overlong_words = 0;

    // Directed: single-character words at both extremes, duplicates, and an
    // overlong word whose flag lands on a dropped character.
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    add_char(8'h80, 1'b0);
    add_char(8'h01, 1'b0);
    add_char(8'h80, 1'b1);
    for (k = 0; k < 18; k++) begin
      if (k == 0) add_char(8'hFF, 1'b0);
      else if (k == 1) add_char(8'h00, 1'b0);
      else add_char(8'h7F - 8'(k % 5) * 8'h11, k == 17);
    end

    // Random words: mostly ordinary lengths, some exactly full, some overlong.
    while (char_queue.size() < 165) begin
      r = $urandom_range(99);
      if (r < 8) len = MAX_LEN;
      else if (r < 18) len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
      else len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) add_char(rand_char(), k == len - 1);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || start) @(posedge clk);
    guard = 0;
    while (key_queue.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);

    if (key_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d sorted characters never arrived", $time, key_queue.size());
    end
    $display("Sent %0d characters in %0d words (%0d past the store limit).",
             chars_sent, words_sent, overlong_words);
    $display("Checked %0d sorted characters, %0d errors.", keys_seen, errors);
    if (errors == 0) begin
      $display("tb_word_letter_sorter: done, clean");
    end else begin
      $display("tb_word_letter_sorter: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Run timed out.");
    $display("tb_word_letter_sorter: done, errors");
    $finish;
  end

endmodule
